>>> sv/itra_pkg.sv
// Package: widths, microcode format, microcode ROM and digit-to-ASCII mapping.
package itra_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int RADIX_W     = 5;
  localparam int FLAGS_W     = 2;
  localparam int CHAR_W      = 7;
  localparam int DIGIT_W     = 4;

  // Radix division: DIV_BITS quotient bits resolved per cycle.
  localparam int DIV_BITS   = 8;
  localparam int DIV_CHUNKS = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_W      = DIV_CHUNKS * DIV_BITS;
  localparam int CHUNK_W    = (DIV_CHUNKS > 1) ? $clog2(DIV_CHUNKS) : 1;

  localparam int IDX_W = $clog2(VALUE_WIDTH);
  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

  localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(8'h2D);
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0] CHAR_UPA   = CHAR_W'(8'h41);
  localparam logic [CHAR_W-1:0] CHAR_LOWA  = CHAR_W'(8'h61);

  localparam int FLAG_UNSIGNED = 0;
  localparam int FLAG_LOWER    = 1;

  localparam int STEP_W = 3;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_LOAD  = 3'd0;
  localparam step_t STEP_DIV   = 3'd1;
  localparam step_t STEP_STORE = 3'd2;
  localparam step_t STEP_SIGN  = 3'd3;
  localparam step_t STEP_RADDR = 3'd4;
  localparam step_t STEP_EMIT  = 3'd5;
  localparam step_t STEP_END   = 3'd6;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_DIV_MORE,
    COND_MORE_DIGITS,
    COND_NOT_LAST
  } cond_t;

  typedef struct packed {
    logic  load;    // take an input beat
    logic  div;     // one chunk of the radix division
    logic  store;   // write remainder digit, quotient becomes dividend
    logic  sign;    // emit '-' when negative, set read index
    logic  emit;    // emit one digit character
    cond_t cond;
    step_t target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic div_more;
    logic more_digits;
    logic neg;
    logic not_last;
  } status_t;

  function automatic ctrl_t ucode(step_t s);
    ctrl_t w;
    w = '{load: 1'b0, div: 1'b0, store: 1'b0, sign: 1'b0, emit: 1'b0,
          cond: COND_NEVER, target: STEP_LOAD};
    case (s)
      STEP_LOAD:  w.load = 1'b1;
      STEP_DIV: begin
        w.div    = 1'b1;
        w.cond   = COND_DIV_MORE;
        w.target = STEP_DIV;
      end
      STEP_STORE: begin
        w.store  = 1'b1;
        w.cond   = COND_MORE_DIGITS;
        w.target = STEP_DIV;
      end
      STEP_SIGN:  w.sign = 1'b1;
      STEP_RADDR: w.cond = COND_NEVER;
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_NOT_LAST;
        w.target = STEP_RADDR;
      end
      STEP_END: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_LOAD;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_LOAD;
      end
    endcase
    return w;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(logic [DIGIT_W-1:0] d, logic lower);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_W'(10)) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else if (lower) begin
      c = CHAR_LOWA + CHAR_W'(d - DIGIT_W'(10));
    end else begin
      c = CHAR_UPA + CHAR_W'(d - DIGIT_W'(10));
    end
    return c;
  endfunction

endpackage

>>> sv/itra_ram.sv
// Generic single-write, single-read RAM with registered read data.
module itra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/itra_seq.sv
// Microcode sequencer: step counter, control ROM, stall and jump logic.
module itra_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  itra_pkg::status_t st,
  output itra_pkg::ctrl_t   ctl,
  output logic              go
);

  itra_pkg::step_t step_r;
  itra_pkg::step_t step_nxt;
  logic            take_jump;

  assign ctl = itra_pkg::ucode(step_r);

  // Hold the step while input is missing or the output register is full.
  assign go = !((ctl.load && !st.in_valid) ||
                ((ctl.emit || (ctl.sign && st.neg)) && !st.out_free));

  always_comb begin
    case (ctl.cond)
      itra_pkg::COND_NEVER:       take_jump = 1'b0;
      itra_pkg::COND_ALWAYS:      take_jump = 1'b1;
      itra_pkg::COND_DIV_MORE:    take_jump = st.div_more;
      itra_pkg::COND_MORE_DIGITS: take_jump = st.more_digits;
      itra_pkg::COND_NOT_LAST:    take_jump = st.not_last;
      default:                    take_jump = 1'b0;
    endcase
    if (!go) begin
      step_nxt = step_r;
    end else if (take_jump) begin
      step_nxt = ctl.target;
    end else begin
      step_nxt = step_r + itra_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= itra_pkg::STEP_LOAD;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

>>> sv/integer_to_radix_ascii_unit.sv
// Top level: integer to ASCII text in radix 2..16, microcoded datapath.
//
// Input channel (in_*): one beat carries value and radix in in_tdata and the
// format flags in in_tuser (bit0 unsigned, bit1 lowercase a-f). A radix below
// 2 is used as 2, above 16 as 16.
// Output channel (out_*): one beat per character, most significant first, a
// leading '-' for a negative value in signed mode; out_tlast marks the final
// character. Zero gives the single character '0'.
// Sequence: a short control program steps a plain datapath: a load step, then
// for each digit the radix divider steps (8 quotient bits per cycle over the
// 32-bit magnitude) and a step that stores the remainder in the digit RAM.
// Then a sign step, a read-address and an emit step per digit character (one
// RAM read turnaround per character) and a closing step.
// One item is in work at a time; in_tready is high only in the load step.
// The result sits in an output register; a stall on out_tready holds the
// program at the emitting step, nothing is dropped. The next item can be
// taken while the final character still waits in that register.
// Reset (rst_n low, synchronous) returns to the load step with the output
// register empty; the digit RAM needs no clearing.
module integer_to_radix_ascii_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] value, [36:32] radix, [39:37] zero
  input  logic [1:0]  in_tuser,   // [1:0] format_flags
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [6:0] character, [7] zero
  output logic        out_tlast   // last
);

  localparam int VW = itra_pkg::VALUE_WIDTH;

  itra_pkg::status_t st;
  itra_pkg::ctrl_t   ctl;
  logic              go;

  // Datapath registers
  logic [itra_pkg::RADIX_W-1:0] radix_r, radix_nxt;
  logic                         lower_r, lower_nxt;
  logic                         neg_r, neg_nxt;
  logic [itra_pkg::DIV_W-1:0]   sh_r, sh_nxt;      // dividend in, quotient out
  logic [itra_pkg::DIGIT_W-1:0] rem_r, rem_nxt;
  logic [itra_pkg::CHUNK_W-1:0] chunk_r, chunk_nxt;
  logic [itra_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [itra_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [itra_pkg::CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic                         out_last_r, out_last_nxt;

  // Input fields
  logic [VW-1:0]                in_value;
  logic [itra_pkg::RADIX_W-1:0] in_radix;
  logic [itra_pkg::RADIX_W-1:0] radix_clamped;
  logic                         in_neg;
  logic [VW-1:0]                in_mag;

  // Divider chunk
  logic [itra_pkg::DIV_W-1:0]   div_sh;
  logic [itra_pkg::DIGIT_W-1:0] div_rem;

  logic [itra_pkg::DIGIT_W-1:0] rd_digit;
  logic                         out_free;
  logic                         last_chunk;

  assign in_value = in_tdata[VW-1:0];
  assign in_radix = in_tdata[VW +: itra_pkg::RADIX_W];

  always_comb begin
    if (in_radix < itra_pkg::RADIX_MIN) begin
      radix_clamped = itra_pkg::RADIX_MIN;
    end else if (in_radix > itra_pkg::RADIX_MAX) begin
      radix_clamped = itra_pkg::RADIX_MAX;
    end else begin
      radix_clamped = in_radix;
    end
  end

  assign in_neg = !in_tuser[itra_pkg::FLAG_UNSIGNED] && in_value[VW-1];
  assign in_mag = in_neg ? (~in_value + VW'(1)) : in_value;

  // Restoring division, DIV_BITS quotient bits per cycle. Remainder stays
  // below the radix, so it fits in a digit.
  always_comb begin
    logic [itra_pkg::RADIX_W-1:0] t;
    logic [itra_pkg::DIGIT_W-1:0] r;
    logic [itra_pkg::DIV_W-1:0]   q;
    r = rem_r;
    q = sh_r;
    for (int k = 0; k < itra_pkg::DIV_BITS; k++) begin
      t = {r, q[itra_pkg::DIV_W-1]};
      q = {q[itra_pkg::DIV_W-2:0], 1'b0};
      if (t >= radix_r) begin
        t    = t - radix_r;
        q[0] = 1'b1;
      end
      r = t[itra_pkg::DIGIT_W-1:0];
    end
    div_sh  = q;
    div_rem = r;
  end

  assign last_chunk = (chunk_r == itra_pkg::CHUNK_W'(itra_pkg::DIV_CHUNKS - 1));
  assign out_free   = !out_valid_r || out_tready;

  assign st.in_valid    = in_tvalid;
  assign st.out_free    = out_free;
  assign st.div_more    = !last_chunk;
  assign st.more_digits = (sh_r != '0) && (count_r < itra_pkg::CNT_W'(VW - 1));
  assign st.neg         = neg_r;
  assign st.not_last    = (idx_r != '0);

  itra_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .ctl   (ctl),
    .go    (go)
  );

  itra_ram #(
    .WIDTH (itra_pkg::DIGIT_W),
    .DEPTH (VW)
  ) u_digits (
    .clk     (clk),
    .wr_en   (ctl.store),
    .wr_addr (count_r[itra_pkg::IDX_W-1:0]),
    .wr_data (rem_r),
    .rd_addr (idx_r),
    .rd_data (rd_digit)
  );

  always_comb begin
    radix_nxt     = radix_r;
    lower_nxt     = lower_r;
    neg_nxt       = neg_r;
    sh_nxt        = sh_r;
    rem_nxt       = rem_r;
    chunk_nxt     = chunk_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_tready;

    if (go) begin
      if (ctl.load) begin
        radix_nxt = radix_clamped;
        lower_nxt = in_tuser[itra_pkg::FLAG_LOWER];
        neg_nxt   = in_neg;
        sh_nxt    = itra_pkg::DIV_W'(in_mag);
        rem_nxt   = '0;
        chunk_nxt = '0;
        count_nxt = '0;
      end
      if (ctl.div) begin
        sh_nxt    = div_sh;
        rem_nxt   = div_rem;
        chunk_nxt = last_chunk ? '0 : chunk_r + itra_pkg::CHUNK_W'(1);
      end
      if (ctl.store) begin
        // quotient already sits in sh_r; restart remainder for next digit
        rem_nxt   = '0;
        count_nxt = count_r + itra_pkg::CNT_W'(1);
      end
      if (ctl.sign) begin
        idx_nxt = itra_pkg::IDX_W'(count_r - itra_pkg::CNT_W'(1));
        if (neg_r) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = itra_pkg::CHAR_MINUS;
          out_last_nxt  = 1'b0;
        end
      end
      if (ctl.emit) begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = itra_pkg::digit_char(rd_digit, lower_r);
        out_last_nxt  = (idx_r == '0);
        if (idx_r != '0) begin
          idx_nxt = idx_r - itra_pkg::IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      chunk_r     <= '0;
      count_r     <= '0;
      neg_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      chunk_r     <= chunk_nxt;
      count_r     <= count_nxt;
      neg_r       <= neg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    radix_r    <= radix_nxt;
    lower_r    <= lower_nxt;
    sh_r       <= sh_nxt;
    rem_r      <= rem_nxt;
    idx_r      <= idx_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_tready  = ctl.load;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_char_r};
  assign out_tlast  = out_last_r;

  // Remainder must stay below the radix while dividing.
  a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.div |-> (itra_pkg::RADIX_W'(rem_r) < radix_r))
    else $error("division remainder not below radix");

  // Digit count never passes the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= itra_pkg::CNT_W'(VW))
    else $error("digit count beyond store depth");

  // An accepted beat starts a fresh conversion.
  a_fresh_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (count_r == '0 && rem_r == '0 && chunk_r == '0))
    else $error("conversion state not cleared on accept");

  // A digit character is never emitted while the output register is blocked.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.emit && go) |-> (!out_valid_r || out_tready))
    else $error("character overwrote a waiting beat");

endmodule
